>>> design/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, constants and the arctangent table for the model-matrix
// composer (CORDIC lanes, carried payload).
// ----------------------------------------------------------------------------
package trs_pkg;

  // cordic datapath widths (x, y in Q4.30, z as phase with 2^32 a full turn)
  localparam int CW         = 34;
  localparam int ZW         = 34;
  localparam int NUM_STEPS  = 30;
  localparam int NUM_LANES  = 3;

  localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(652032874);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);

  // lane index of each angle
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } lane_t;

  // fields that ride along with the angles
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] scale_x;
    logic [31:0] scale_y;
    logic [31:0] scale_z;
  } pay_t;

  // arctangent of 2^-i in turns, scaled by 2^32
  function automatic logic [31:0] atan_lut(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> design/trs_if.sv
// ----------------------------------------------------------------------------
// trs_if
// Valid/ready channels of the composer: pose beats in, matrix beats out.
// ----------------------------------------------------------------------------
interface trs_in_if #(parameter int ANGLE_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           pos_x;
  logic signed [31:0]           pos_y;
  logic signed [31:0]           pos_z;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [31:0]           scale_x;
  logic signed [31:0]           scale_y;
  logic signed [31:0]           scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, pitch_angle, yaw_angle,
                  roll_angle, scale_x, scale_y, scale_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, pitch_angle, yaw_angle,
                  roll_angle, scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic signed [31:0] trans_x;
  logic signed [31:0] trans_y;
  logic signed [31:0] trans_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, output ready);
endinterface

>>> design/trs_model_matrix_compose_top.sv
// pipeline: an accepted beat passes 1 phase setup register, 30 cordic cells
// and 5 matrix stages before it leaves as its result beat
// throughput: one beat per cycle; the pipeline advances whenever the
// output register is empty or being taken
// reset: synchronous active-low rst_n clears all valid flags; no stored state
// ----------------------------------------------------------------------------
// trs_model_matrix_compose_top
// Composes the affine model matrix T*Ry*Rx*Rz*S from position, Euler angles
// and scale, using a chain of CORDIC cells and a short matrix pipeline.
// ----------------------------------------------------------------------------
module trs_model_matrix_compose_top #(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  trs_in_if.sink     in_ch,
  trs_out_if.source  out_ch
);

  localparam int NS = trs_pkg::NUM_STEPS;

  logic en;
  logic vld_chain [NS+1];
  trs_pkg::lane_t lane_chain [NS+1][trs_pkg::NUM_LANES];
  trs_pkg::pay_t  pay_chain  [NS+1];
  trs_pkg::lane_t lane_nxt   [trs_pkg::NUM_LANES];
  trs_pkg::pay_t  pay_nxt;
  logic [ANGLE_BITS-1:0] ang [trs_pkg::NUM_LANES];
  logic vld_r;
  trs_pkg::lane_t lane_r [trs_pkg::NUM_LANES];
  trs_pkg::pay_t  pay_r;
  logic           mat_vld;
  logic signed [31:0] mat_m [9];
  trs_pkg::pay_t  mat_pay;

  assign en          = !mat_vld || out_ch.ready;
  assign in_ch.ready = en;

  assign ang[trs_pkg::LANE_X] = in_ch.pitch_angle;
  assign ang[trs_pkg::LANE_Y] = in_ch.yaw_angle;
  assign ang[trs_pkg::LANE_Z] = in_ch.roll_angle;

  // angle to phase, folded into the right half plane
  always_comb begin
    logic [31:0] ph;
    logic signed [trs_pkg::ZW-1:0] z;
    for (int i = 0; i < trs_pkg::NUM_LANES; i++) begin
      ph = {ang[i], {(32-ANGLE_BITS){1'b0}}};
      z  = trs_pkg::ZW'($signed(ph));
      lane_nxt[i].x   = trs_pkg::CORDIC_GAIN;
      lane_nxt[i].y   = '0;
      lane_nxt[i].neg = 1'b0;
      if (z > trs_pkg::QUARTER_TURN) begin
        lane_nxt[i].z   = z - trs_pkg::HALF_TURN;
        lane_nxt[i].neg = 1'b1;
      end else if (z < -trs_pkg::QUARTER_TURN) begin
        lane_nxt[i].z   = z + trs_pkg::HALF_TURN;
        lane_nxt[i].neg = 1'b1;
      end else begin
        lane_nxt[i].z   = z;
      end
    end
  end

  assign pay_nxt.pos_x   = in_ch.pos_x;
  assign pay_nxt.pos_y   = in_ch.pos_y;
  assign pay_nxt.pos_z   = in_ch.pos_z;
  assign pay_nxt.scale_x = in_ch.scale_x;
  assign pay_nxt.scale_y = in_ch.scale_y;
  assign pay_nxt.scale_z = in_ch.scale_z;

  // setup stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_ch.valid;
    end
  end

  // setup stage data
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      pay_r  <= pay_nxt;
    end
  end

  assign vld_chain[0]  = vld_r;
  assign lane_chain[0] = lane_r;
  assign pay_chain[0]  = pay_r;

  // cordic cell chain
  for (genvar g = 0; g < NS; g++) begin : g_cell
    trs_cordic_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_in   (vld_chain[g]),
      .lane_in  (lane_chain[g]),
      .pay_in   (pay_chain[g]),
      .vld_out  (vld_chain[g+1]),
      .lane_out (lane_chain[g+1]),
      .pay_out  (pay_chain[g+1])
    );
  end

  // matrix back end
  trs_mat_stage #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld_chain[NS]),
    .lane_in (lane_chain[NS]),
    .pay_in  (pay_chain[NS]),
    .vld_out (mat_vld),
    .m_out   (mat_m),
    .pay_out (mat_pay)
  );

  // result beat
  assign out_ch.valid   = mat_vld;
  assign out_ch.m00     = mat_m[0];
  assign out_ch.m01     = mat_m[1];
  assign out_ch.m02     = mat_m[2];
  assign out_ch.m10     = mat_m[3];
  assign out_ch.m11     = mat_m[4];
  assign out_ch.m12     = mat_m[5];
  assign out_ch.m20     = mat_m[6];
  assign out_ch.m21     = mat_m[7];
  assign out_ch.m22     = mat_m[8];
  assign out_ch.trans_x = mat_pay.pos_x;
  assign out_ch.trans_y = mat_pay.pos_y;
  assign out_ch.trans_z = mat_pay.pos_z;

endmodule

>>> design/trs_cordic_cell.sv
// ----------------------------------------------------------------------------
// trs_cordic_cell
// One CORDIC micro-rotation for all three angle lanes, registered, with the
// carried payload handed on to the next cell.
// ----------------------------------------------------------------------------
module trs_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  trs_pkg::lane_t   lane_in  [trs_pkg::NUM_LANES],
  input  trs_pkg::pay_t    pay_in,
  output logic             vld_out,
  output trs_pkg::lane_t   lane_out [trs_pkg::NUM_LANES],
  output trs_pkg::pay_t    pay_out
);

  localparam logic signed [trs_pkg::ZW-1:0] ATAN =
    $signed({{(trs_pkg::ZW-32){1'b0}}, trs_pkg::atan_lut(STEP)});

  logic           vld_r;
  trs_pkg::lane_t lane_r   [trs_pkg::NUM_LANES];
  trs_pkg::lane_t lane_nxt [trs_pkg::NUM_LANES];
  trs_pkg::pay_t  pay_r;

  // rotate toward zero residual phase
  always_comb begin
    for (int i = 0; i < trs_pkg::NUM_LANES; i++) begin
      lane_nxt[i].neg = lane_in[i].neg;
      if (lane_in[i].z >= 0) begin
        lane_nxt[i].x = lane_in[i].x - (lane_in[i].y >>> STEP);
        lane_nxt[i].y = lane_in[i].y + (lane_in[i].x >>> STEP);
        lane_nxt[i].z = lane_in[i].z - ATAN;
      end else begin
        lane_nxt[i].x = lane_in[i].x + (lane_in[i].y >>> STEP);
        lane_nxt[i].y = lane_in[i].y - (lane_in[i].x >>> STEP);
        lane_nxt[i].z = lane_in[i].z + ATAN;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  // lane and payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
      pay_r  <= pay_in;
    end
  end

  assign vld_out  = vld_r;
  assign lane_out = lane_r;
  assign pay_out  = pay_r;

endmodule

>>> design/trs_mat_stage.sv
// ----------------------------------------------------------------------------
// trs_mat_stage
// Back end of the composer: rounds sine/cosine, forms the Y-X-Z rotation,
// scales the columns and saturates, over five registered stages.
// ----------------------------------------------------------------------------
module trs_mat_stage #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  trs_pkg::lane_t     lane_in [trs_pkg::NUM_LANES],
  input  trs_pkg::pay_t      pay_in,
  output logic               vld_out,
  output logic signed [31:0] m_out [9],
  output trs_pkg::pay_t      pay_out
);

  localparam int SW = FRAC_BITS + 3;
  localparam int RW = SW + 1;
  localparam int PW = RW + 33;
  localparam int CSH = 30 - FRAC_BITS;
  localparam logic signed [trs_pkg::CW-1:0] C_HALF =
    $signed({{(trs_pkg::CW-1){1'b0}}, 1'b1} << (CSH - 1));
  localparam logic signed [PW-1:0] P_HALF =
    $signed({{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] SAT_HI = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(64'sd2147483648);

  // rounded product of two sine/cosine-sized values
  function automatic logic signed [SW-1:0] fm(input logic signed [SW-1:0] a,
                                              input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] p;
    logic signed [2*SW-1:0] h;
    h = $signed({{(2*SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
    p = a * b;
    p = (p + h) >>> FRAC_BITS;
    return p[SW-1:0];
  endfunction

  logic [4:0] vld_r;
  trs_pkg::pay_t pay_a_r, pay_b_r, pay_c_r, pay_d_r, pay_e_r;

  // stage a: sign fold and rounding of sine/cosine
  logic signed [SW-1:0] sin_r [trs_pkg::NUM_LANES];
  logic signed [SW-1:0] cos_r [trs_pkg::NUM_LANES];
  logic signed [SW-1:0] sin_nxt [trs_pkg::NUM_LANES];
  logic signed [SW-1:0] cos_nxt [trs_pkg::NUM_LANES];

  always_comb begin
    logic signed [trs_pkg::CW-1:0] cx, sy;
    for (int i = 0; i < trs_pkg::NUM_LANES; i++) begin
      cx = lane_in[i].neg ? -lane_in[i].x : lane_in[i].x;
      sy = lane_in[i].neg ? -lane_in[i].y : lane_in[i].y;
      cx = (cx + C_HALF) >>> CSH;
      sy = (sy + C_HALF) >>> CSH;
      cos_nxt[i] = cx[SW-1:0];
      sin_nxt[i] = sy[SW-1:0];
    end
  end

  // stage b: pairwise products
  logic signed [SW-1:0] sx_b_r, sz_b_r, cz_b_r, ysx_r, ycx_r;
  logic signed [SW-1:0] cycz_r, cysz_r, sycz_r, sysz_r;
  logic signed [SW-1:0] sycx_r, cxsz_r, cxcz_r, cycx_r;

  // stage c: rotation entries
  logic signed [RW-1:0] rot_r [9];
  logic signed [RW-1:0] rot_nxt [9];

  always_comb begin
    rot_nxt[0] = RW'(cycz_r) + RW'(fm(ysx_r, sz_b_r));
    rot_nxt[1] = RW'(fm(ysx_r, cz_b_r)) - RW'(cysz_r);
    rot_nxt[2] = RW'(sycx_r);
    rot_nxt[3] = RW'(cxsz_r);
    rot_nxt[4] = RW'(cxcz_r);
    rot_nxt[5] = -RW'(sx_b_r);
    rot_nxt[6] = RW'(fm(ycx_r, sz_b_r)) - RW'(sycz_r);
    rot_nxt[7] = RW'(sysz_r) + RW'(fm(ycx_r, cz_b_r));
    rot_nxt[8] = RW'(cycx_r);
  end

  // stage d: scale columns
  logic signed [PW-1:0] prod_r [9];
  logic signed [31:0]   scl    [trs_pkg::NUM_LANES];

  assign scl[0] = $signed(pay_c_r.scale_x);
  assign scl[1] = $signed(pay_c_r.scale_y);
  assign scl[2] = $signed(pay_c_r.scale_z);

  // stage e: round and saturate
  logic signed [31:0] m_r   [9];
  logic signed [31:0] m_nxt [9];

  always_comb begin
    logic signed [PW-1:0] t;
    for (int k = 0; k < 9; k++) begin
      t = (prod_r[k] + P_HALF) >>> FRAC_BITS;
      if (t > SAT_HI) begin
        m_nxt[k] = 32'sh7FFFFFFF;
      end else if (t < SAT_LO) begin
        m_nxt[k] = 32'sh80000000;
      end else begin
        m_nxt[k] = t[31:0];
      end
    end
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_in};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      sin_r   <= sin_nxt;
      cos_r   <= cos_nxt;
      pay_a_r <= pay_in;

      sx_b_r  <= sin_r[trs_pkg::LANE_X];
      sz_b_r  <= sin_r[trs_pkg::LANE_Z];
      cz_b_r  <= cos_r[trs_pkg::LANE_Z];
      ysx_r   <= fm(sin_r[trs_pkg::LANE_Y], sin_r[trs_pkg::LANE_X]);
      ycx_r   <= fm(cos_r[trs_pkg::LANE_Y], sin_r[trs_pkg::LANE_X]);
      cycz_r  <= fm(cos_r[trs_pkg::LANE_Y], cos_r[trs_pkg::LANE_Z]);
      cysz_r  <= fm(cos_r[trs_pkg::LANE_Y], sin_r[trs_pkg::LANE_Z]);
      sycz_r  <= fm(sin_r[trs_pkg::LANE_Y], cos_r[trs_pkg::LANE_Z]);
      sysz_r  <= fm(sin_r[trs_pkg::LANE_Y], sin_r[trs_pkg::LANE_Z]);
      sycx_r  <= fm(sin_r[trs_pkg::LANE_Y], cos_r[trs_pkg::LANE_X]);
      cxsz_r  <= fm(cos_r[trs_pkg::LANE_X], sin_r[trs_pkg::LANE_Z]);
      cxcz_r  <= fm(cos_r[trs_pkg::LANE_X], cos_r[trs_pkg::LANE_Z]);
      cycx_r  <= fm(cos_r[trs_pkg::LANE_Y], cos_r[trs_pkg::LANE_X]);
      pay_b_r <= pay_a_r;

      rot_r   <= rot_nxt;
      pay_c_r <= pay_b_r;

      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= PW'(rot_r[k]) * PW'(scl[k % 3]);
      end
      pay_d_r <= pay_c_r;

      m_r     <= m_nxt;
      pay_e_r <= pay_d_r;
    end
  end

  assign vld_out = vld_r[4];
  assign m_out   = m_r;
  assign pay_out = pay_e_r;

endmodule

>>> bench/trs_tb_pkg.sv
// ----------------------------------------------------------------------------
// trs_tb_pkg
// Pose and matrix beat types, the matrix predictor and the scoreboard class
// that holds the expected matrices of the composer testbench.
// ----------------------------------------------------------------------------
package trs_tb_pkg;

  typedef struct {
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] pitch, yaw, roll;
    logic signed [31:0] scl_x, scl_y, scl_z;
  } pose_t;

  typedef struct {
    logic signed [31:0] m [9];
    logic signed [31:0] t [3];
  } matrix_t;

  localparam int FB = 16;

  // arctangent of 2^-i, 2^32 per turn
  localparam longint ATAN_TURNS [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  function automatic longint rnd_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shr(a * b, FB);
  endfunction

  // rotation-mode cordic on a binary angle, results in Q.16
  function automatic void angle_sincos(logic signed [15:0] ang,
                                       output longint sn, output longint cs);
    longint ph, x, y, dx, dy;
    bit flip;
    ph = longint'(ang) <<< 16;
    x = 652032874;
    y = 0;
    flip = 0;
    if (ph > 64'sd1073741824) begin
      ph -= 64'sd2147483648;
      flip = 1;
    end else if (ph < -64'sd1073741824) begin
      ph += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ph >= 0) begin
        x -= dx; y += dy; ph -= ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; ph += ATAN_TURNS[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    cs = rnd_shr(x, 30 - FB);
    sn = rnd_shr(y, 30 - FB);
  endfunction

  function automatic matrix_t compose_matrix(pose_t p);
    matrix_t res;
    longint sx, cx, sy, cy, sz, cz, ysx, ycx, v;
    longint rot [9];
    longint scl [3];
    angle_sincos(p.pitch, sx, cx);
    angle_sincos(p.yaw, sy, cy);
    angle_sincos(p.roll, sz, cz);
    scl[0] = p.scl_x; scl[1] = p.scl_y; scl[2] = p.scl_z;
    ysx = qmul(sy, sx);
    ycx = qmul(cy, sx);
    rot[0] = qmul(cy, cz) + qmul(ysx, sz);
    rot[1] = qmul(ysx, cz) - qmul(cy, sz);
    rot[2] = qmul(sy, cx);
    rot[3] = qmul(cx, sz);
    rot[4] = qmul(cx, cz);
    rot[5] = -sx;
    rot[6] = qmul(ycx, sz) - qmul(sy, cz);
    rot[7] = qmul(sy, sz) + qmul(ycx, cz);
    rot[8] = qmul(cy, cx);
    // scale by column, clamp to 32 bits
    for (int k = 0; k < 9; k++) begin
      v = qmul(rot[k], scl[k % 3]);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      res.m[k] = v[31:0];
    end
    res.t[0] = p.pos_x; res.t[1] = p.pos_y; res.t[2] = p.pos_z;
    return res;
  endfunction

  class matrix_scoreboard;
    matrix_t pending [$];
    int      errors;

    function void note_pose(pose_t p);
      pending.push_back(compose_matrix(p));
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      bit bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected matrix beat");
        return;
      end
      want = pending.pop_front();
      bad = 0;
      for (int k = 0; k < 9; k++)
        if (got.m[k] !== want.m[k]) begin
          bad = 1;
          if (errors < 10)
            $display("m%0d%0d: expected %h actual %h", k / 3, k % 3,
                     want.m[k], got.m[k]);
        end
      for (int k = 0; k < 3; k++)
        if (got.t[k] !== want.t[k]) begin
          bad = 1;
          if (errors < 10)
            $display("trans %0d: expected %h actual %h", k, want.t[k], got.t[k]);
        end
      if (bad) errors++;
    endfunction
  endclass

endpackage

>>> bench/tb_trs_model_matrix_compose_top.sv
// ----------------------------------------------------------------------------
// tb_trs_model_matrix_compose_top
// Drives pose beats into the composer and checks every matrix beat against
// a bit-exact predictor, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_trs_model_matrix_compose_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_stall;
  bit   done;
  trs_tb_pkg::matrix_scoreboard board;

  trs_in_if  in_ch ();
  trs_out_if out_ch ();

  trs_model_matrix_compose_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 1) ? 32'sh00010000 : 32'shFFFF0000;
      3: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_ang();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(16'h4000 * $urandom_range(0, 3));
      3: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4) - 2);
      default: return $urandom;
    endcase
  endfunction

  // one pose beat, gaps per current idling setting
  task automatic send_pose(trs_tb_pkg::pose_t p);
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pos_x       <= p.pos_x;
    in_ch.pos_y       <= p.pos_y;
    in_ch.pos_z       <= p.pos_z;
    in_ch.pitch_angle <= p.pitch;
    in_ch.yaw_angle   <= p.yaw;
    in_ch.roll_angle  <= p.roll;
    in_ch.scale_x     <= p.scl_x;
    in_ch.scale_y     <= p.scl_y;
    in_ch.scale_z     <= p.scl_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_pose(p);
  endtask

  task automatic send_random(int n);
    trs_tb_pkg::pose_t p;
    for (int i = 0; i < n; i++) begin
      p.pos_x = rand_q(); p.pos_y = rand_q(); p.pos_z = rand_q();
      p.pitch = rand_ang(); p.yaw = rand_ang(); p.roll = rand_ang();
      p.scl_x = rand_q(); p.scl_y = rand_q(); p.scl_z = rand_q();
      send_pose(p);
    end
  endtask

  // stop sending and wait for every expected beat
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    trs_tb_pkg::matrix_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.m[0] = out_ch.m00; got.m[1] = out_ch.m01; got.m[2] = out_ch.m02;
      got.m[3] = out_ch.m10; got.m[4] = out_ch.m11; got.m[5] = out_ch.m12;
      got.m[6] = out_ch.m20; got.m[7] = out_ch.m21; got.m[8] = out_ch.m22;
      got.t[0] = out_ch.trans_x; got.t[1] = out_ch.trans_y;
      got.t[2] = out_ch.trans_z;
      board.check_matrix(got);
    end
    out_ch.ready <= !done && ($urandom_range(0, 99) >= recv_stall);
  end

  // stimulus
  initial begin
    trs_tb_pkg::pose_t p;
    logic signed [15:0] angs [8];
    board = new();
    rst_n = 0;
    done = 0;
    send_idle = 0;
    recv_stall = 0;
    in_ch.valid = 0;
    in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
    in_ch.pitch_angle = 0; in_ch.yaw_angle = 0; in_ch.roll_angle = 0;
    in_ch.scale_x = 0; in_ch.scale_y = 0; in_ch.scale_z = 0;
    out_ch.ready = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: quarter turns, half turn, field extremes, saturation
    angs = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh8000, 16'sh7FFF,
             16'sh4001, 16'shBFFF, 16'sh2000};
    for (int i = 0; i < 8; i++) begin
      p.pos_x = i[0] ? 32'sh7FFFFFFF : 32'sh80000000;
      p.pos_y = i[1] ? 32'sh80000000 : 32'sh7FFFFFFF;
      p.pos_z = 32'sh00010000 * i;
      p.pitch = angs[i]; p.yaw = angs[(i + 3) % 8]; p.roll = angs[(i + 5) % 8];
      p.scl_x = 32'sh00010000; p.scl_y = 32'sh00010000; p.scl_z = 32'sh00010000;
      send_pose(p);
    end
    for (int i = 0; i < 8; i++) begin
      p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
      p.pitch = angs[i]; p.yaw = angs[7 - i]; p.roll = angs[(i + 2) % 8];
      p.scl_x = i[0] ? 32'sh7FFFFFFF : 32'sh80000000;
      p.scl_y = i[1] ? 32'sh80000000 : 32'sh7FFFFFFF;
      p.scl_z = i[2] ? 32'sh7FFFFFFF : 32'sh80000000;
      send_pose(p);
    end

    // random phases
    send_random(450);
    // hold off until the pipe is empty
    drain();
    send_idle = 51;
    send_random(450);
    send_idle = 0;
    recv_stall = 51;
    send_random(450);
    send_idle = 11;
    recv_stall = 11;
    send_random(450);

    drain();
    repeat (50) @(posedge clk);
    done = 1;
    if (board.errors == 0 && board.pending.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
